@@ rtl/tcf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt filter package
// Shared constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tcf_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_CALIB_SAMPLES = 2'd0;
  localparam logic [1:0] CFG_STEP_MS       = 2'd1;
  localparam logic [1:0] CFG_BLEND_WEIGHT  = 2'd2;

  // CORDIC datapath widths: x/y working width, angle accumulator width (Q20 deg)
  localparam int CORDIC_W = 36;
  localparam int Z_W      = 32;
  localparam int ATAN_LEN = 24;

  // 180 degrees in Q20
  localparam logic signed [Z_W-1:0] DEG180_Q20 = 32'sd188743680;

  // Divider numerator width
  localparam int DIV_W = 42;

  // atan(2^-i) in degrees, Q20
  function automatic logic signed [Z_W-1:0] atan_q20(input logic [4:0] idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      5'd0:    a = 32'sd47185920;
      5'd1:    a = 32'sd27855475;
      5'd2:    a = 32'sd14718068;
      5'd3:    a = 32'sd7471121;
      5'd4:    a = 32'sd3750058;
      5'd5:    a = 32'sd1876857;
      5'd6:    a = 32'sd938658;
      5'd7:    a = 32'sd469357;
      5'd8:    a = 32'sd234682;
      5'd9:    a = 32'sd117342;
      5'd10:   a = 32'sd58671;
      5'd11:   a = 32'sd29335;
      5'd12:   a = 32'sd14668;
      5'd13:   a = 32'sd7334;
      5'd14:   a = 32'sd3667;
      5'd15:   a = 32'sd1833;
      5'd16:   a = 32'sd917;
      5'd17:   a = 32'sd458;
      5'd18:   a = 32'sd229;
      5'd19:   a = 32'sd115;
      5'd20:   a = 32'sd57;
      5'd21:   a = 32'sd29;
      5'd22:   a = 32'sd14;
      5'd23:   a = 32'sd7;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/tilt_complementary_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt complementary filter
// Fuses accelerometer tilt (CORDIC atan2) with integrated gyro rate into
// roll and pitch estimates in 1/128 degree.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The block handles one sample at a time and
// holds in_stall high until the sample's result is loaded into the output
// register; the next sample may be taken while that result is still waiting.
// A calibration sample adds its gyro rates to the running sums; the last one
// also runs two offset divisions. Seeding and tracking samples run, in turn
// under the sequencer, the squared-magnitude products, two passes of the
// iterative CORDIC (shorter when the residual reaches zero), the bit-serial
// square root and, for tracking, the gyro and blend products. The products
// all run on one shared 18x36 multiplier. Estimates carry ANGLE_FRAC_BITS
// fraction bits internally.
// ----------------------------------------------------------------------------
module tilt_complementary_filter #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // sample in
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  // result out
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [15:0] pitch_angle,
  output logic               estimate_valid
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int EST_W = F + 9;
  localparam int ACC_W = F + 10;
  localparam int INC_W = 32;
  localparam int OW    = EST_W + 9;
  localparam int LIM   = 180 << F;
  localparam int CW    = tcf_pkg::CORDIC_W;
  localparam int DW    = tcf_pkg::DIV_W;

  typedef enum logic [19:0] {
    S_IDLE       = 20'h00001,
    S_DIV_GO     = 20'h00002,
    S_DIV_WAIT   = 20'h00004,
    S_SQ_AY      = 20'h00008,
    S_SQ_AZ      = 20'h00010,
    S_SQ_SUM     = 20'h00020,
    S_ROLL_GO    = 20'h00040,
    S_ROLL_WAIT  = 20'h00080,
    S_ROOT_GO    = 20'h00100,
    S_ROOT_WAIT  = 20'h00200,
    S_PITCH_GO   = 20'h00400,
    S_PITCH_WAIT = 20'h00800,
    S_SEED       = 20'h01000,
    S_INC_R      = 20'h02000,
    S_INC_P      = 20'h04000,
    S_INC_W      = 20'h08000,
    S_BL1        = 20'h10000,
    S_BL2        = 20'h20000,
    S_BL3        = 20'h40000,
    S_DONE       = 20'h80000
  } state_t;

  typedef enum logic [1:0] {
    PH_CAL   = 2'd0,
    PH_SEED  = 2'd1,
    PH_TRACK = 2'd2
  } phase_t;

  // configuration registers
  logic [15:0] calib_samples;
  logic [9:0]  step_ms;
  logic [15:0] blend_weight;

  // filter state
  state_t                   state, state_next;
  phase_t                   phase;
  logic [15:0]              sample_counter;
  logic signed [32:0]       roll_rate_sum;
  logic signed [32:0]       pitch_rate_sum;
  logic signed [23:0]       roll_bias;
  logic signed [23:0]       pitch_bias;
  logic signed [EST_W-1:0]  roll_estimate;
  logic signed [EST_W-1:0]  pitch_estimate;
  logic                     cal_item;
  logic                     axis;

  // sample and working registers
  logic signed [15:0]       ax_r, ay_r, az_r, gx_r, gy_r;
  logic signed [53:0]       prod_r;
  logic signed [53:0]       mix_r;
  logic [31:0]              sq_r;
  logic [29:0]              mag;
  logic signed [ACC_W-1:0]  acc_roll;
  logic signed [ACC_W-1:0]  acc_pitch;
  logic signed [INC_W-1:0]  inc_roll;
  logic signed [INC_W-1:0]  inc_pitch;

  // combinational
  logic                      in_acc;
  logic                      out_free;
  logic [15:0]               calib_n;
  logic                      cnt_hit;
  logic signed [32:0]        sum_sel;
  logic signed [DW-1:0]      div_num;
  logic signed [DW-1:0]      div_q;
  logic                      div_done;
  logic                      div_start;
  logic signed [25:0]        d_roll, d_pitch;
  logic signed [INC_W-1:0]   inc_now;
  logic signed [EST_W-1:0]   est_sel;
  logic signed [INC_W-1:0]   inc_sel;
  logic signed [ACC_W-1:0]   acc_sel;
  logic [16:0]               w_inv;
  logic signed [17:0]        mul_a;
  logic signed [CW-1:0]      mul_b;
  logic signed [53:0]        prod_w;
  logic signed [54:0]        mix_sum;
  logic signed [EST_W-1:0]   blend_est;
  logic                      cordic_start;
  logic signed [CW-1:0]      cordic_y, cordic_x;
  logic signed [tcf_pkg::Z_W-1:0] cordic_z;
  logic                      cordic_done;
  logic signed [ACC_W-1:0]   acc_now;
  logic                      root_start;
  logic                      root_done;
  logic [29:0]               root;

  // saturate to +-180 degrees
  function automatic logic signed [EST_W-1:0] sat_est(input logic signed [54:0] v);
    logic signed [54:0] r;
    if (v > LIM)       r = 55'(LIM);
    else if (v < -LIM) r = -55'(LIM);
    else               r = v;
    return EST_W'(r);
  endfunction

  // rescale estimate to 1/128 degree, round half up, clamp
  function automatic logic signed [15:0] to_out(input logic signed [EST_W-1:0] e);
    logic signed [OW-1:0] v;
    v = (OW'(e) <<< 7) + OW'(1 <<< (F - 1));
    v = v >>> F;
    if (v > 23040)       v = OW'(23040);
    else if (v < -23040) v = -OW'(23040);
    return 16'(v);
  endfunction

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // calibration terms
  always_comb begin
    calib_n = (calib_samples == '0) ? 16'd1 : calib_samples;
    cnt_hit = (({1'b0, sample_counter} + 17'd1) >= {1'b0, calib_n});
    sum_sel = axis ? pitch_rate_sum : roll_rate_sum;
    div_num = (DW'(sum_sel) <<< 8)
            + DW'($signed({1'b0, calib_n[15:1]}));
  end

  // gyro increment and blend terms
  always_comb begin
    d_roll    = (26'(gx_r) <<< 8) - 26'(roll_bias);
    d_pitch   = (26'(gy_r) <<< 8) - 26'(pitch_bias);
    inc_now   = INC_W'(((prod_r <<< F) + 65536) >>> 17);
    est_sel   = axis ? pitch_estimate : roll_estimate;
    inc_sel   = axis ? inc_pitch : inc_roll;
    acc_sel   = axis ? acc_pitch : acc_roll;
    w_inv     = 17'h10000 - {1'b0, blend_weight};
    mix_sum   = (55'(mix_r) + 55'(prod_r) + 55'sd8388608) >>> 24;
    blend_est = sat_est(mix_sum);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ_AY: begin
        mul_a = 18'(ay_r);
        mul_b = CW'(ay_r);
      end
      S_SQ_AZ: begin
        mul_a = 18'(az_r);
        mul_b = CW'(az_r);
      end
      S_INC_R: begin
        mul_a = $signed({8'd0, step_ms});
        mul_b = CW'(d_roll);
      end
      S_INC_P: begin
        mul_a = $signed({8'd0, step_ms});
        mul_b = CW'(d_pitch);
      end
      S_BL1: begin
        mul_a = $signed({1'b0, w_inv});
        mul_b = (CW'(est_sel) <<< 8) + CW'(inc_sel);
      end
      S_BL2: begin
        mul_a = $signed({2'b0, blend_weight});
        mul_b = CW'(acc_sel) <<< 8;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  // CORDIC operand select and result rounding
  always_comb begin
    cordic_start = (state == S_ROLL_GO) || (state == S_PITCH_GO);
    if (state == S_ROLL_GO) begin
      cordic_y = CW'(ay_r) <<< 14;
      cordic_x = CW'(az_r) <<< 14;
    end else begin
      cordic_y = -(CW'(ax_r) <<< 14);
      cordic_x = $signed({{(CW-30){1'b0}}, mag});
    end
    acc_now = ACC_W'((cordic_z + (1 <<< (19 - F))) >>> (20 - F));
  end

  assign div_start  = (state == S_DIV_GO);
  assign root_start = (state == S_ROOT_GO);

  tcf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_num),
    .denom (calib_n),
    .done  (div_done),
    .quot  (div_q)
  );

  tcf_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand ({sq_r, 28'd0}),
    .done     (root_done),
    .root     (root)
  );

  tcf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .y_in  (cordic_y),
    .x_in  (cordic_x),
    .done  (cordic_done),
    .z_out (cordic_z)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (phase == PH_CAL) state_next = cnt_hit ? S_DIV_GO : S_DONE;
          else                 state_next = S_SQ_AY;
        end
      end
      S_DIV_GO:     state_next = S_DIV_WAIT;
      S_DIV_WAIT:   if (div_done) state_next = axis ? S_DONE : S_DIV_GO;
      S_SQ_AY:      state_next = S_SQ_AZ;
      S_SQ_AZ:      state_next = S_SQ_SUM;
      S_SQ_SUM:     state_next = S_ROLL_GO;
      S_ROLL_GO:    state_next = S_ROLL_WAIT;
      S_ROLL_WAIT:  if (cordic_done) state_next = S_ROOT_GO;
      S_ROOT_GO:    state_next = S_ROOT_WAIT;
      S_ROOT_WAIT:  if (root_done) state_next = S_PITCH_GO;
      S_PITCH_GO:   state_next = S_PITCH_WAIT;
      S_PITCH_WAIT: begin
        if (cordic_done) state_next = (phase == PH_SEED) ? S_SEED : S_INC_R;
      end
      S_SEED:       state_next = S_DONE;
      S_INC_R:      state_next = S_INC_P;
      S_INC_P:      state_next = S_INC_W;
      S_INC_W:      state_next = S_BL1;
      S_BL1:        state_next = S_BL2;
      S_BL2:        state_next = S_BL3;
      S_BL3:        state_next = axis ? S_DONE : S_BL1;
      S_DONE:       if (out_free) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_samples <= 16'd10000;
      step_ms       <= 10'd10;
      blend_weight  <= 16'd3277;
    end else if (cfg_wen) begin
      case (cfg_index)
        tcf_pkg::CFG_CALIB_SAMPLES: calib_samples <= cfg_data;
        tcf_pkg::CFG_STEP_MS:       step_ms       <= cfg_data[9:0];
        tcf_pkg::CFG_BLEND_WEIGHT:  blend_weight  <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_CAL;
      sample_counter <= '0;
      roll_rate_sum  <= '0;
      pitch_rate_sum <= '0;
      roll_bias      <= '0;
      pitch_bias     <= '0;
      roll_estimate  <= '0;
      pitch_estimate <= '0;
      cal_item       <= 1'b0;
      axis           <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            axis     <= 1'b0;
            cal_item <= (phase == PH_CAL);
            if (phase == PH_CAL) begin
              roll_rate_sum  <= roll_rate_sum + 33'(gyro_x);
              pitch_rate_sum <= pitch_rate_sum + 33'(gyro_y);
              sample_counter <= sample_counter + 16'd1;
            end
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (axis) begin
              pitch_bias <= 24'(div_q);
              phase      <= PH_SEED;
            end else begin
              roll_bias <= 24'(div_q);
              axis      <= 1'b1;
            end
          end
        end
        S_SEED: begin
          roll_estimate  <= sat_est(55'(acc_roll));
          pitch_estimate <= sat_est(55'(acc_pitch));
          phase          <= PH_TRACK;
        end
        S_BL3: begin
          if (axis) begin
            pitch_estimate <= blend_est;
          end else begin
            roll_estimate <= blend_est;
            axis          <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // sample capture and working datapath
  always_ff @(posedge clk) begin
    prod_r <= prod_w;
    if (in_acc) begin
      ax_r <= accel_x;
      ay_r <= accel_y;
      az_r <= accel_z;
      gx_r <= gyro_x;
      gy_r <= gyro_y;
    end
    case (state)
      S_SQ_AZ:      sq_r <= 32'(prod_r);
      S_SQ_SUM:     sq_r <= sq_r + 32'(prod_r);
      S_ROLL_WAIT:  if (cordic_done) acc_roll <= acc_now;
      S_ROOT_WAIT:  if (root_done) mag <= root;
      S_PITCH_WAIT: if (cordic_done) acc_pitch <= acc_now;
      S_INC_P:      inc_roll <= inc_now;
      S_INC_W:      inc_pitch <= inc_now;
      S_BL2:        mix_r <= prod_r;
      default: ;
    endcase
  end

  // output register: result beat waits here until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      roll_angle     <= cal_item ? 16'sd0 : to_out(roll_estimate);
      pitch_angle    <= cal_item ? 16'sd0 : to_out(pitch_estimate);
      estimate_valid <= !cal_item;
    end
  end

endmodule

@@ rtl/tcf_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt filter CORDIC
// Iterative vectoring CORDIC, one micro-rotation per cycle. Returns the angle
// of (x, y) in Q20 degrees. Stops early when y reaches zero.
// ----------------------------------------------------------------------------
module tcf_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [tcf_pkg::CORDIC_W-1:0] y_in,
  input  logic signed [tcf_pkg::CORDIC_W-1:0] x_in,
  output logic                                done,
  output logic signed [tcf_pkg::Z_W-1:0]      z_out
);

  localparam int N  = (STEPS < tcf_pkg::ATAN_LEN) ? STEPS : tcf_pkg::ATAN_LEN;
  localparam int IW = $clog2(N + 1);

  logic                                busy;
  logic signed [tcf_pkg::CORDIC_W-1:0] x_r;
  logic signed [tcf_pkg::CORDIC_W-1:0] y_r;
  logic signed [tcf_pkg::Z_W-1:0]      z_r;
  logic [IW-1:0]                       i_r;
  logic signed [tcf_pkg::CORDIC_W-1:0] xs;
  logic signed [tcf_pkg::CORDIC_W-1:0] ys;
  logic signed [tcf_pkg::Z_W-1:0]      atan;
  logic                                stop;

  // shifted terms and table lookup for the current step
  always_comb begin
    xs   = x_r >>> i_r;
    ys   = y_r >>> i_r;
    atan = tcf_pkg::atan_q20(5'(i_r));
    stop = (i_r == IW'(N)) || (y_r == '0);
  end

  assign z_out = z_r;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && stop) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // rotation datapath; left half-plane folded by +-180 first
  always_ff @(posedge clk) begin
    if (start) begin
      i_r <= '0;
      if (x_in < 0) begin
        z_r <= (y_in >= 0) ? tcf_pkg::DEG180_Q20 : -tcf_pkg::DEG180_Q20;
        x_r <= -x_in;
        y_r <= -y_in;
      end else begin
        z_r <= '0;
        x_r <= x_in;
        y_r <= y_in;
      end
    end else if (busy && !stop) begin
      i_r <= i_r + 1'b1;
      if (y_r > 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan;
      end
    end
  end

endmodule

@@ rtl/tcf_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt filter square root
// Bit-serial floor integer square root of a 60-bit radicand, one result bit
// per cycle.
// ----------------------------------------------------------------------------
module tcf_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [59:0] radicand,
  output logic        done,
  output logic [29:0] root
);

  logic        busy;
  logic [59:0] v_r;
  logic [59:0] r_r;
  logic [59:0] bit_r;
  logic [59:0] trial;
  logic        ge;

  // trial subtract
  always_comb begin
    trial = r_r + bit_r;
    ge    = (v_r >= trial);
  end

  assign root = r_r[29:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bit_r[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // root/remainder datapath
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      r_r   <= '0;
      bit_r <= 60'd1 << 58;
    end else if (busy) begin
      if (ge) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

@@ rtl/tcf_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt filter divider
// Restoring divider, one quotient bit per cycle. Signed numerator, unsigned
// nonzero divisor, quotient rounded toward minus infinity.
// ----------------------------------------------------------------------------
module tcf_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [tcf_pkg::DIV_W-1:0] numer,
  input  logic [15:0]                      denom,
  output logic                             done,
  output logic signed [tcf_pkg::DIV_W-1:0] quot
);

  logic                      busy;
  logic [tcf_pkg::DIV_W-1:0] q_r;
  logic [15:0]               rem_r;
  logic [15:0]               d_r;
  logic                      neg_r;
  logic [5:0]                cnt_r;
  logic [16:0]               rem_sh;
  logic                      ge;
  logic                      rem_nz;

  // one restoring step
  always_comb begin
    rem_sh = {rem_r, q_r[tcf_pkg::DIV_W-1]};
    ge     = (rem_sh >= {1'b0, d_r});
    rem_nz = (rem_r != '0);
    quot   = neg_r ? (-$signed(q_r) - $signed({{(tcf_pkg::DIV_W-1){1'b0}}, rem_nz}))
                   : $signed(q_r);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt_r == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // magnitude division
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= (numer < 0);
      q_r   <= (numer < 0) ? -numer : numer;
      rem_r <= '0;
      d_r   <= denom;
      cnt_r <= 6'(tcf_pkg::DIV_W);
    end else if (busy) begin
      rem_r <= ge ? 16'(rem_sh - {1'b0, d_r}) : rem_sh[15:0];
      q_r   <= {q_r[tcf_pkg::DIV_W-2:0], ge};
      cnt_r <= cnt_r - 6'd1;
    end
  end

endmodule
